### src/ssh_pkg.sv
// ----------------------------------------------------------------------------
// ssh_pkg
// Shared widths, register map, reset values and types for the speech segment
// hysteresis segmenter.
// ----------------------------------------------------------------------------
package ssh_pkg;

  localparam int unsigned PROB_W   = 17;
  localparam int unsigned THR_W    = 17;
  localparam int unsigned CNT_W    = 10;
  localparam int unsigned HOP_W    = 13;
  localparam int unsigned FRAME_W  = 21;
  localparam int unsigned SAMPLE_W = 33;
  localparam int unsigned ADDR_W   = 5;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [PROB_W-1:0]  ONE_Q16    = 17'h10000;
  localparam logic [FRAME_W-1:0] MAX_FRAMES = 21'h100000;

  // register indexes (byte address = 4 * index)
  localparam logic [REG_IDX_W-1:0] REG_SPEECH_THRESHOLD   = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MIN_SPEECH_FRAMES  = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MIN_SILENCE_FRAMES = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_SPEECH_PAD_FRAMES  = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_HOP_LENGTH         = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_FRAME_TOTAL        = 3'd5;

  localparam logic [THR_W-1:0]   RST_SPEECH_THRESHOLD   = 17'd32768;
  localparam logic [CNT_W-1:0]   RST_MIN_SPEECH_FRAMES  = 10'd8;
  localparam logic [CNT_W-1:0]   RST_MIN_SILENCE_FRAMES = 10'd8;
  localparam logic [CNT_W-1:0]   RST_SPEECH_PAD_FRAMES  = 10'd4;
  localparam logic [HOP_W-1:0]   RST_HOP_LENGTH         = 13'd160;
  localparam logic [FRAME_W-1:0] RST_FRAME_TOTAL        = 21'h100000;

  typedef struct packed {
    logic [THR_W-1:0]   speech_threshold;
    logic [CNT_W-1:0]   min_speech_frames;
    logic [CNT_W-1:0]   min_silence_frames;
    logic [CNT_W-1:0]   speech_pad_frames;
    logic [HOP_W-1:0]   hop_length;
    logic [FRAME_W-1:0] frame_total;
  } ssh_cfg_t;

  // padded segment bounds in frames, waiting for hop scaling
  typedef struct packed {
    logic [FRAME_W-1:0] start_frame;
    logic [FRAME_W-1:0] end_frame;
    logic               at_end;
  } ssh_seg_t;

endpackage

### src/ssh_cfg_regs.sv
// ----------------------------------------------------------------------------
// ssh_cfg_regs
// APB-style register file holding the segmenter configuration.
// ----------------------------------------------------------------------------
module ssh_cfg_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [ssh_pkg::ADDR_W-1:0]  paddr,
  input  logic [ssh_pkg::DATA_W-1:0]  pwdata,
  output logic [ssh_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output ssh_pkg::ssh_cfg_t           cfg_o
);
  import ssh_pkg::*;

  ssh_cfg_t               cfg_q, cfg_d;
  logic [REG_IDX_W-1:0]   idx;
  logic                   wr_en;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_SPEECH_THRESHOLD:   cfg_d.speech_threshold   = pwdata[THR_W-1:0];
        REG_MIN_SPEECH_FRAMES:  cfg_d.min_speech_frames  = pwdata[CNT_W-1:0];
        REG_MIN_SILENCE_FRAMES: cfg_d.min_silence_frames = pwdata[CNT_W-1:0];
        REG_SPEECH_PAD_FRAMES:  cfg_d.speech_pad_frames  = pwdata[CNT_W-1:0];
        REG_HOP_LENGTH:         cfg_d.hop_length         = pwdata[HOP_W-1:0];
        REG_FRAME_TOTAL:        cfg_d.frame_total        = pwdata[FRAME_W-1:0];
        default:                cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_SPEECH_THRESHOLD:   prdata = DATA_W'(cfg_q.speech_threshold);
      REG_MIN_SPEECH_FRAMES:  prdata = DATA_W'(cfg_q.min_speech_frames);
      REG_MIN_SILENCE_FRAMES: prdata = DATA_W'(cfg_q.min_silence_frames);
      REG_SPEECH_PAD_FRAMES:  prdata = DATA_W'(cfg_q.speech_pad_frames);
      REG_HOP_LENGTH:         prdata = DATA_W'(cfg_q.hop_length);
      REG_FRAME_TOTAL:        prdata = DATA_W'(cfg_q.frame_total);
      default:                prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.speech_threshold   <= RST_SPEECH_THRESHOLD;
      cfg_q.min_speech_frames  <= RST_MIN_SPEECH_FRAMES;
      cfg_q.min_silence_frames <= RST_MIN_SILENCE_FRAMES;
      cfg_q.speech_pad_frames  <= RST_SPEECH_PAD_FRAMES;
      cfg_q.hop_length         <= RST_HOP_LENGTH;
      cfg_q.frame_total        <= RST_FRAME_TOTAL;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

### src/ssh_tracker.sv
// ----------------------------------------------------------------------------
// ssh_tracker
// Per-frame hysteresis state update; registers padded segment bounds.
// ----------------------------------------------------------------------------
module ssh_tracker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        accept_i,
  input  logic [ssh_pkg::PROB_W-1:0]  nonspeech_prob_i,
  input  ssh_pkg::ssh_cfg_t           cfg_i,
  input  logic                        seg_take_i,
  output logic                        seg_valid_o,
  output ssh_pkg::ssh_seg_t           seg_o
);
  import ssh_pkg::*;

  logic [FRAME_W-1:0] frame_index_q, frame_index_d;
  logic               triggered_q, triggered_d;
  logic [FRAME_W-1:0] cand_start_q, cand_start_d;
  logic               cand_start_valid_q, cand_start_valid_d;
  logic [FRAME_W-1:0] cand_end_q, cand_end_d;
  logic               cand_end_valid_q, cand_end_valid_d;
  logic [FRAME_W-1:0] segment_start_q, segment_start_d;
  logic               seg_valid_q, seg_valid_d;
  ssh_seg_t           seg_q, seg_d;

  logic [PROB_W-1:0]  score;
  logic               speech;
  logic [FRAME_W-1:0] total;
  logic               last_frame;
  logic [FRAME_W-1:0] start_gap, end_gap;
  logic               close_quiet, close_end, emit;
  logic [FRAME_W-1:0] end_sel, pad_ext;
  logic [FRAME_W:0]   end_sum;

  assign score  = nonspeech_prob_i[PROB_W-1] ? '0 : ONE_Q16 - nonspeech_prob_i;
  assign speech = score >= cfg_i.speech_threshold;

  always_comb begin
    if (cfg_i.frame_total == '0) begin
      total = FRAME_W'(1);
    end else if (cfg_i.frame_total > MAX_FRAMES) begin
      total = MAX_FRAMES;
    end else begin
      total = cfg_i.frame_total;
    end
  end

  assign last_frame = ({1'b0, frame_index_q} + (FRAME_W+1)'(1)) >= {1'b0, total};
  assign start_gap  = frame_index_q - cand_start_q;
  assign end_gap    = frame_index_q - cand_end_q;
  assign pad_ext    = FRAME_W'(cfg_i.speech_pad_frames);

  // hysteresis update
  always_comb begin
    triggered_d        = triggered_q;
    cand_start_d       = cand_start_q;
    cand_start_valid_d = cand_start_valid_q;
    cand_end_d         = cand_end_q;
    cand_end_valid_d   = cand_end_valid_q;
    segment_start_d    = segment_start_q;
    close_quiet        = 1'b0;
    if (!triggered_q) begin
      if (speech) begin
        if (!cand_start_valid_q) begin
          cand_start_d       = frame_index_q;
          cand_start_valid_d = 1'b1;
        end else if (start_gap >= FRAME_W'(cfg_i.min_speech_frames)) begin
          triggered_d        = 1'b1;
          segment_start_d    = cand_start_q;
          cand_start_valid_d = 1'b0;
        end
      end else begin
        cand_start_valid_d = 1'b0;
      end
    end else begin
      if (!speech) begin
        if (!cand_end_valid_q) begin
          cand_end_d       = frame_index_q;
          cand_end_valid_d = 1'b1;
        end else if (end_gap >= FRAME_W'(cfg_i.min_silence_frames)) begin
          triggered_d      = 1'b0;
          close_quiet      = 1'b1;
          cand_end_valid_d = 1'b0;
        end
      end else begin
        cand_end_valid_d = 1'b0;
      end
    end
  end

  // padded bounds; an end-of-run close applies only while still triggered
  assign close_end = last_frame & triggered_d;
  assign emit      = close_quiet | close_end;
  assign end_sel   = close_end ? total : cand_end_q;
  assign end_sum   = {1'b0, end_sel} + {1'b0, pad_ext};

  always_comb begin
    seg_d.at_end      = close_end;
    seg_d.start_frame = (segment_start_d > pad_ext) ? segment_start_d - pad_ext : '0;
    seg_d.end_frame   = (end_sum > {1'b0, total}) ? total : end_sum[FRAME_W-1:0];
  end

  always_comb begin
    seg_valid_d = seg_valid_q;
    if (accept_i) begin
      seg_valid_d = emit;
    end else if (seg_take_i) begin
      seg_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_index_q      <= '0;
      triggered_q        <= 1'b0;
      cand_start_q       <= '0;
      cand_start_valid_q <= 1'b0;
      cand_end_q         <= '0;
      cand_end_valid_q   <= 1'b0;
      segment_start_q    <= '0;
      seg_valid_q        <= 1'b0;
    end else begin
      seg_valid_q <= seg_valid_d;
      if (accept_i) begin
        if (last_frame) begin
          frame_index_q      <= '0;
          triggered_q        <= 1'b0;
          cand_start_q       <= '0;
          cand_start_valid_q <= 1'b0;
          cand_end_q         <= '0;
          cand_end_valid_q   <= 1'b0;
          segment_start_q    <= '0;
        end else begin
          frame_index_q      <= frame_index_q + FRAME_W'(1);
          triggered_q        <= triggered_d;
          cand_start_q       <= cand_start_d;
          cand_start_valid_q <= cand_start_valid_d;
          cand_end_q         <= cand_end_d;
          cand_end_valid_q   <= cand_end_valid_d;
          segment_start_q    <= segment_start_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i && emit) begin
      seg_q <= seg_d;
    end
  end

  assign seg_valid_o = seg_valid_q;
  assign seg_o       = seg_q;

  // candidates only live in the matching phase
  a_start_cand_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cand_start_valid_q |-> !triggered_q)
    else $error("start candidate held while triggered");

  a_end_cand_trig: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cand_end_valid_q |-> triggered_q)
    else $error("end candidate held while idle");

  a_cand_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cand_start_valid_q |-> (cand_start_q <= frame_index_q))
    else $error("start candidate ahead of frame index");

endmodule

### src/ssh_scaler.sv
// ----------------------------------------------------------------------------
// ssh_scaler
// Scales padded frame bounds by hop length into the output register.
// ----------------------------------------------------------------------------
module ssh_scaler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          seg_valid_i,
  input  ssh_pkg::ssh_seg_t             seg_i,
  input  logic [ssh_pkg::HOP_W-1:0]     hop_length_i,
  output logic                          seg_take_o,
  output logic                          seg_ready_o,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ssh_pkg::SAMPLE_W-1:0]  start_sample_o,
  output logic [ssh_pkg::SAMPLE_W-1:0]  end_sample_o,
  output logic                          closed_at_end_o
);
  import ssh_pkg::*;

  localparam int unsigned PROD_W = FRAME_W + HOP_W;

  logic                 out_valid_q;
  logic [SAMPLE_W-1:0]  start_q, end_q;
  logic                 at_end_q;
  logic [PROD_W-1:0]    start_prod, end_prod;

  // frames <= 2^20 and hop < 2^13, so the product never exceeds 33 bits
  assign start_prod = PROD_W'(seg_i.start_frame) * PROD_W'(hop_length_i);
  assign end_prod   = PROD_W'(seg_i.end_frame) * PROD_W'(hop_length_i);

  assign seg_ready_o = !out_valid_q || !out_stall_i;
  assign seg_take_o  = seg_valid_i && seg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (seg_ready_o) begin
      out_valid_q <= seg_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seg_take_o) begin
      start_q  <= start_prod[SAMPLE_W-1:0];
      end_q    <= end_prod[SAMPLE_W-1:0];
      at_end_q <= seg_i.at_end;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign start_sample_o  = start_q;
  assign end_sample_o    = end_q;
  assign closed_at_end_o = at_end_q;

endmodule

### src/speech_segment_hysteresis_top.sv
// ----------------------------------------------------------------------------
// speech_segment_hysteresis_top
// Voice-activity hysteresis segmenter: frame probabilities in, padded
// sample-offset segments out.
// ----------------------------------------------------------------------------
// One non-speech probability (Q1.16) is taken per cycle, with no gaps, while
// in_stall_o is low. Each item updates the hysteresis state in the same cycle
// it is taken; the state loop is a single compare/subtract/add pass, which is
// what bounds the rate at one item per clock. A frame that closes a segment
// (by silence or by reaching the run length) yields one result on the outputs:
// the padded frame bounds are registered at the edge that takes it, and the
// two hop-length multiplies fill the output register once it can take them.
// Frames that close nothing give no result. in_stall_o rises only when both
// pipeline registers hold results and out_stall_i is high. Configuration is
// written through the APB port while the block is idle, a rule for the user
// that the block does not enforce; pready is always high, reads are zero-wait.
// ----------------------------------------------------------------------------
module speech_segment_hysteresis_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ssh_pkg::ADDR_W-1:0]    paddr,
  input  logic [ssh_pkg::DATA_W-1:0]    pwdata,
  output logic [ssh_pkg::DATA_W-1:0]    prdata,
  output logic                          pready,
  // frame items
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [ssh_pkg::PROB_W-1:0]    nonspeech_prob_i,
  // segment items
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [ssh_pkg::SAMPLE_W-1:0]  start_sample_o,
  output logic [ssh_pkg::SAMPLE_W-1:0]  end_sample_o,
  output logic                          closed_at_end_o
);
  import ssh_pkg::*;

  ssh_cfg_t cfg;
  ssh_seg_t seg;
  logic     seg_valid;
  logic     seg_take;
  logic     seg_ready;
  logic     accept;

  // frame stage may load whenever it is empty or drains this cycle
  assign in_stall_o = seg_valid && !seg_ready;
  assign accept     = in_valid_i && !in_stall_o;

  ssh_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  ssh_tracker u_tracker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .accept_i         (accept),
    .nonspeech_prob_i (nonspeech_prob_i),
    .cfg_i            (cfg),
    .seg_take_i       (seg_take),
    .seg_valid_o      (seg_valid),
    .seg_o            (seg)
  );

  ssh_scaler u_scaler (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .seg_valid_i     (seg_valid),
    .seg_i           (seg),
    .hop_length_i    (cfg.hop_length),
    .seg_take_o      (seg_take),
    .seg_ready_o     (seg_ready),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .start_sample_o  (start_sample_o),
    .end_sample_o    (end_sample_o),
    .closed_at_end_o (closed_at_end_o)
  );

  // input back-pressure only when the frame stage is full and blocked
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (seg_valid && out_valid_o && out_stall_i))
    else $error("input stalled with room in the pipeline");

  // a blocked frame-stage result is held, not overwritten
  a_seg_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seg_valid && !seg_ready) |=> (seg_valid && $stable(seg)))
    else $error("frame stage result lost under stall");

  // a taken frame-stage result shows up at the output next cycle
  a_seg_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    seg_take |=> out_valid_o)
    else $error("taken result did not reach the output register");

endmodule

### sim/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the speech segment hysteresis segmenter.
// ----------------------------------------------------------------------------
// A queue-fed driver offers frame probabilities on the valid/stall input side
// while a monitor predicts every accepted frame with a cycle-free copy of the
// hysteresis state machine. Predicted segments are queued and compared field
// by field with every segment the block hands out. Registers are programmed
// over APB between phases, once the block has drained, and read back.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import ssh_pkg::*;

  localparam int unsigned HALF_PERIOD  = 5;
  localparam int unsigned RUN_LIMIT_NS = 5_000_000;
  localparam int unsigned DRAIN_CYCLES = 10;   // two-stage output pipe plus margin
  localparam int unsigned HOLD_CYCLES  = 300;  // long receiver hold-off
  localparam int unsigned RAND_FRAMES  = 330;
  localparam int unsigned PHASE_FRAMES = 50;
  localparam logic [PROB_W-1:0] PROB_MAX = '1;

  typedef struct {
    logic [PROB_W-1:0] prob;
    int unsigned       gap;
  } frame_item_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] start_sample;
    logic [SAMPLE_W-1:0] end_sample;
    logic                closed_at_end;
  } segment_t;

  // DUT ports; every input starts at a known value
  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                psel       = 1'b0;
  logic                penable    = 1'b0;
  logic                pwrite     = 1'b0;
  logic [ADDR_W-1:0]   paddr      = '0;
  logic [DATA_W-1:0]   pwdata     = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid_i = 1'b0;
  logic                in_stall_o;
  logic [PROB_W-1:0]   nonspeech_prob_i = '0;
  logic                out_valid_o;
  logic                out_stall_i = 1'b0;
  logic [SAMPLE_W-1:0] start_sample_o;
  logic [SAMPLE_W-1:0] end_sample_o;
  logic                closed_at_end_o;

  speech_segment_hysteresis_top dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .nonspeech_prob_i(nonspeech_prob_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .start_sample_o  (start_sample_o),
    .end_sample_o    (end_sample_o),
    .closed_at_end_o (closed_at_end_o)
  );

  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Bench state
  // --------------------------------------------------------------------------
  frame_item_t frame_q[$];        // frames waiting to be offered
  segment_t    seg_expect_q[$];   // predicted segments not yet seen

  int unsigned err_cnt       = 0;
  int unsigned frames_queued = 0;
  int unsigned frames_taken  = 0;
  int unsigned segs_checked  = 0;
  int unsigned in_stall_hits = 0;
  int unsigned phase_cnt     = 0;

  bit tx_calm = 1'b0;             // sender offers back to back
  bit rx_calm = 1'b0;             // receiver draws no random stalls
  int unsigned hold_req  = 0;     // bumped by the sequencer to ask for a hold-off
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned stall_left = 0;
  bit          stall_drawn = 1'b0;

  logic frame_taken = 1'b0;       // item accepted at the last rising edge
  logic seg_taken   = 1'b0;       // segment accepted at the last rising edge

  // --------------------------------------------------------------------------
  // Segmenter prediction: register copy plus hysteresis state
  // --------------------------------------------------------------------------
  ssh_cfg_t cfg_shadow;

  logic [FRAME_W-1:0] frame_pos;    // frame index inside the current run
  logic               in_segment;   // triggered flag
  logic [FRAME_W-1:0] rise_at;      // first frame of the current speech run
  logic               rise_armed;
  logic [FRAME_W-1:0] fall_at;      // first quiet frame while in a segment
  logic               fall_armed;
  logic [FRAME_W-1:0] seg_open_at;

  // frames times hop, saturating at the 33-bit output range
  function automatic logic [SAMPLE_W-1:0] frames_to_samples(input logic [FRAME_W:0] frames);
    logic [FRAME_W+HOP_W:0] prod;
    prod = frames * cfg_shadow.hop_length;
    return (prod > {{(FRAME_W+HOP_W+1-SAMPLE_W){1'b0}}, {SAMPLE_W{1'b1}}}) ?
           {SAMPLE_W{1'b1}} : prod[SAMPLE_W-1:0];
  endfunction

  function automatic segment_t padded_segment(input logic [FRAME_W:0] seg_start,
                                              input logic [FRAME_W:0] seg_end,
                                              input logic [FRAME_W:0] run_len,
                                              input logic             at_end);
    segment_t           seg;
    logic [FRAME_W:0]   lo;
    logic [FRAME_W+1:0] hi;
    lo = (seg_start > cfg_shadow.speech_pad_frames) ?
         seg_start - cfg_shadow.speech_pad_frames : '0;
    hi = seg_end + cfg_shadow.speech_pad_frames;
    if (hi > {1'b0, run_len}) hi = {1'b0, run_len};
    seg.start_sample  = frames_to_samples(lo);
    seg.end_sample    = frames_to_samples(hi[FRAME_W:0]);
    seg.closed_at_end = at_end;
    return seg;
  endfunction

  // One frame through the hysteresis; returns 1 when a segment closes.
  function automatic bit segment_step(input logic [PROB_W-1:0] prob, output segment_t seg);
    logic [PROB_W-1:0] score;
    logic              is_speech;
    logic [FRAME_W:0]  run_len;
    logic [FRAME_W:0]  idx;
    bit                hit;
    hit = 1'b0;
    seg = '0;
    // probability at or above one leaves no speech score
    score     = (prob >= ONE_Q16) ? '0 : ONE_Q16 - prob;
    is_speech = score >= cfg_shadow.speech_threshold;
    idx       = {1'b0, frame_pos};
    // zero run length behaves as one, anything past the maximum is clamped
    run_len = {1'b0, cfg_shadow.frame_total};
    if (run_len == '0) run_len = (FRAME_W+1)'(1);
    if (run_len > {1'b0, MAX_FRAMES}) run_len = {1'b0, MAX_FRAMES};

    if (!in_segment) begin
      if (is_speech) begin
        if (!rise_armed) begin
          rise_at    = frame_pos;
          rise_armed = 1'b1;
        end else if (frame_pos - rise_at >= cfg_shadow.min_speech_frames) begin
          in_segment  = 1'b1;
          seg_open_at = rise_at;
          rise_armed  = 1'b0;
        end
      end else begin
        rise_armed = 1'b0;
      end
    end else begin
      if (!is_speech) begin
        if (!fall_armed) begin
          fall_at    = frame_pos;
          fall_armed = 1'b1;
        end else if (frame_pos - fall_at >= cfg_shadow.min_silence_frames) begin
          in_segment = 1'b0;
          seg        = padded_segment({1'b0, seg_open_at}, {1'b0, fall_at}, run_len, 1'b0);
          hit        = 1'b1;
          fall_armed = 1'b0;
        end
      end else begin
        fall_armed = 1'b0;
      end
    end

    // last frame of the run: flush an open segment, then start over
    if (idx + 1 >= run_len) begin
      if (in_segment) begin
        seg = padded_segment({1'b0, seg_open_at}, run_len, run_len, 1'b1);
        hit = 1'b1;
      end
      frame_pos   = '0;
      in_segment  = 1'b0;
      rise_at     = '0;
      rise_armed  = 1'b0;
      fall_at     = '0;
      fall_armed  = 1'b0;
      seg_open_at = '0;
    end else begin
      frame_pos = frame_pos + 1'b1;
    end
    return hit;
  endfunction

  // --------------------------------------------------------------------------
  // Monitor: predicts accepted items, checks accepted segments
  // --------------------------------------------------------------------------
  always @(posedge clk_i) begin
    segment_t want;
    segment_t pred;
    frame_taken <= rst_ni && in_valid_i && !in_stall_o;
    seg_taken   <= rst_ni && out_valid_o && !out_stall_i;
    if (rst_ni) begin
      if (in_valid_i && in_stall_o) in_stall_hits++;
      if (in_valid_i && !in_stall_o) begin
        frames_taken++;
        if (segment_step(nonspeech_prob_i, pred)) seg_expect_q.push_back(pred);
      end
      if (out_valid_o && !out_stall_i) begin
        if (seg_expect_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected segment start %0d end %0d closed_at_end %0d",
                   $time, start_sample_o, end_sample_o, closed_at_end_o);
        end else begin
          want = seg_expect_q.pop_front();
          segs_checked++;
          if (start_sample_o !== want.start_sample) begin
            err_cnt++;
            $display("%0t: start_sample expected %0d actual %0d",
                     $time, want.start_sample, start_sample_o);
          end
          if (end_sample_o !== want.end_sample) begin
            err_cnt++;
            $display("%0t: end_sample expected %0d actual %0d",
                     $time, want.end_sample, end_sample_o);
          end
          if (closed_at_end_o !== want.closed_at_end) begin
            err_cnt++;
            $display("%0t: closed_at_end expected %0d actual %0d",
                     $time, want.closed_at_end, closed_at_end_o);
          end
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Driver: offers queued frames, idling per item as drawn at queue time.
  // A held item stays put until the monitor saw it accepted.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    frame_item_t item;
    if (rst_ni && !(in_valid_i && !frame_taken)) begin
      if (frame_q.size() == 0) begin
        in_valid_i <= 1'b0;
      end else if (frame_q[0].gap > 0) begin
        frame_q[0].gap = frame_q[0].gap - 1;
        in_valid_i <= 1'b0;
      end else begin
        item = frame_q.pop_front();
        in_valid_i       <= 1'b1;
        nonspeech_prob_i <= item.prob;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Receiver: a random stall per segment, plus the long hold-off on
  // request, counted here so the sender keeps pushing meanwhile.
  // --------------------------------------------------------------------------
  always @(negedge clk_i) begin
    int unsigned n;
    if (seg_taken) stall_drawn = 1'b0;
    if (hold_left > 0) begin
      hold_left = hold_left - 1;
      out_stall_i <= 1'b1;
    end else if (hold_seen != hold_req) begin
      hold_seen = hold_req;
      hold_left = HOLD_CYCLES - 1;
      out_stall_i <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left = stall_left - 1;
      out_stall_i <= 1'b1;
    end else if (out_valid_o && !stall_drawn && !rx_calm) begin
      stall_drawn = 1'b1;
      n = $urandom_range(0, 3);
      stall_left = (n > 0) ? n - 1 : 0;
      out_stall_i <= (n > 0);
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_frame(input logic [PROB_W-1:0] prob);
    frame_item_t item;
    item.prob = prob;
    item.gap  = tx_calm ? 0 : $urandom_range(0, 3);
    frame_q.push_back(item);
    frames_queued++;
  endtask

  // probability whose score reaches the threshold (any value when none can)
  function automatic logic [PROB_W-1:0] speech_prob();
    if (cfg_shadow.speech_threshold == '0 || cfg_shadow.speech_threshold > ONE_Q16)
      return PROB_W'($urandom_range(0, PROB_MAX));
    return PROB_W'($urandom_range(0, ONE_Q16 - cfg_shadow.speech_threshold));
  endfunction

  // probability whose score stays below the threshold, up to the field limit
  function automatic logic [PROB_W-1:0] quiet_prob();
    if (cfg_shadow.speech_threshold == '0 || cfg_shadow.speech_threshold > ONE_Q16)
      return PROB_W'($urandom_range(0, PROB_MAX));
    return PROB_W'($urandom_range(ONE_Q16 + 1 - cfg_shadow.speech_threshold, PROB_MAX));
  endfunction

  task automatic apb_cycle(input bit wr, input logic [REG_IDX_W-1:0] idx,
                           input logic [DATA_W-1:0] wdata, output logic [DATA_W-1:0] rdata);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= wdata;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // write a register, mirror it in the shadow copy, read it back
  task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [DATA_W-1:0] value);
    logic [DATA_W-1:0] rd;
    logic [DATA_W-1:0] want;
    apb_cycle(1'b1, idx, value, rd);
    want = '0;
    case (idx)
      REG_SPEECH_THRESHOLD: begin
        cfg_shadow.speech_threshold = value[THR_W-1:0];
        want[THR_W-1:0] = value[THR_W-1:0];
      end
      REG_MIN_SPEECH_FRAMES: begin
        cfg_shadow.min_speech_frames = value[CNT_W-1:0];
        want[CNT_W-1:0] = value[CNT_W-1:0];
      end
      REG_MIN_SILENCE_FRAMES: begin
        cfg_shadow.min_silence_frames = value[CNT_W-1:0];
        want[CNT_W-1:0] = value[CNT_W-1:0];
      end
      REG_SPEECH_PAD_FRAMES: begin
        cfg_shadow.speech_pad_frames = value[CNT_W-1:0];
        want[CNT_W-1:0] = value[CNT_W-1:0];
      end
      REG_HOP_LENGTH: begin
        cfg_shadow.hop_length = value[HOP_W-1:0];
        want[HOP_W-1:0] = value[HOP_W-1:0];
      end
      REG_FRAME_TOTAL: begin
        cfg_shadow.frame_total = value[FRAME_W-1:0];
        want[FRAME_W-1:0] = value[FRAME_W-1:0];
      end
      default: ;
    endcase
    apb_cycle(1'b0, idx, '0, rd);
    if (rd !== want) begin
      err_cnt++;
      $display("%0t: register %0d read expected %0d actual %0d", $time, idx, want, rd);
    end
  endtask

  task automatic program_all(input logic [DATA_W-1:0] thr, input logic [DATA_W-1:0] min_sp,
                             input logic [DATA_W-1:0] min_sil, input logic [DATA_W-1:0] pad,
                             input logic [DATA_W-1:0] hop, input logic [DATA_W-1:0] total);
    reg_write(REG_SPEECH_THRESHOLD, thr);
    reg_write(REG_MIN_SPEECH_FRAMES, min_sp);
    reg_write(REG_MIN_SILENCE_FRAMES, min_sil);
    reg_write(REG_SPEECH_PAD_FRAMES, pad);
    reg_write(REG_HOP_LENGTH, hop);
    reg_write(REG_FRAME_TOTAL, total);
    phase_cnt++;
  endtask

  // all frames taken, all segments out, then let the pipe go quiet
  task automatic drain();
    while (frame_q.size() != 0 || in_valid_i) @(posedge clk_i);
    while (seg_expect_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // --------------------------------------------------------------------------
  // Sequencer
  // --------------------------------------------------------------------------
  initial begin
    int unsigned rand_frames;
    int unsigned phase_start;
    int unsigned min_sp;
    int unsigned min_sil;
    logic [DATA_W-1:0] thr, pad, hop, total;

    // shadow copy and state as they come out of reset
    cfg_shadow.speech_threshold   = RST_SPEECH_THRESHOLD;
    cfg_shadow.min_speech_frames  = RST_MIN_SPEECH_FRAMES;
    cfg_shadow.min_silence_frames = RST_MIN_SILENCE_FRAMES;
    cfg_shadow.speech_pad_frames  = RST_SPEECH_PAD_FRAMES;
    cfg_shadow.hop_length         = RST_HOP_LENGTH;
    cfg_shadow.frame_total        = RST_FRAME_TOTAL;
    frame_pos   = '0;
    in_segment  = 1'b0;
    rise_at     = '0;
    rise_armed  = 1'b0;
    fall_at     = '0;
    fall_armed  = 1'b0;
    seg_open_at = '0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: short runs at 12 frames, open after two speech frames,
    // close on the second quiet one. Covers score equal to threshold, score
    // one below it, probability at one and above, start padding floored at
    // zero, a silence close landing on the last frame of a run, and a
    // segment still open when the run ends.
    tx_calm = 1'b1;
    program_all(32'd32768, 32'd1, 32'd0, 32'd2, 32'd160, 32'd12);
    push_frame('0);
    push_frame(17'd32768);          // score exactly at threshold
    push_frame(ONE_Q16);
    push_frame(PROB_MAX);           // close: start floored at zero
    push_frame('0);
    push_frame('0);
    push_frame(17'd65535);          // score of one lsb
    push_frame(17'd32769);          // one below threshold, closes
    push_frame('0);
    push_frame('0);
    push_frame(17'd65537);          // above one: score zero
    push_frame(17'd100000);         // silence close on the last frame
    repeat (12) push_frame('0);     // open through the whole next run
    drain();

    // Back pressure: every second frame closes a segment at the run end,
    // while the receiver holds off long enough for the input to back up.
    program_all(32'd32768, 32'd0, 32'd0, 32'd0, 32'd1, 32'd2);
    hold_req++;
    repeat (60) push_frame(speech_prob());
    drain();

    // Widest counts and padding, a hop of 4096, with a frame total above the
    // maximum so the run length clamps: a speech run shorter than the count
    // never opens a segment.
    program_all(32'd1, 32'd1023, 32'd1023, 32'd1023, 32'd4096, 32'h1F_FFFF);
    repeat (40) push_frame(speech_prob());
    drain();

    // Randomized phases: fresh register set each time, bursts of speech and
    // quiet sized around the current counts, a little pure noise mixed in.
    rand_frames = 0;
    while (rand_frames < RAND_FRAMES) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 5))
        0:       thr = 32'd0;
        1:       thr = DATA_W'(ONE_Q16);
        2:       thr = $urandom_range(65537, 131071);   // nothing counts as speech
        default: thr = $urandom_range(1, 65535);
      endcase
      min_sp  = $urandom_range(0, 6);
      min_sil = $urandom_range(0, 6);
      case ($urandom_range(0, 3))
        0:       pad = 32'd0;
        1:       pad = 32'd1023;
        default: pad = $urandom_range(0, 12);
      endcase
      case ($urandom_range(0, 3))
        0:       hop = 32'd1;
        1:       hop = 32'd4096;
        default: hop = $urandom_range(1, 4096);
      endcase
      case ($urandom_range(0, 7))
        0:       total = 32'd0;                          // acts as a one-frame run
        1:       total = 32'd1;
        2:       total = 32'd2;
        3:       total = DATA_W'(RST_FRAME_TOTAL);
        default: total = $urandom_range(3, 90);
      endcase
      program_all(thr, min_sp, min_sil, pad, hop, total);
      phase_start = frames_queued;
      while (frames_queued - phase_start < PHASE_FRAMES) begin
        if ($urandom_range(0, 9) == 0) begin
          push_frame(PROB_W'($urandom_range(0, PROB_MAX)));
        end else begin
          repeat ($urandom_range(0, min_sp + 3)) push_frame(speech_prob());
          repeat ($urandom_range(0, min_sil + 3)) push_frame(quiet_prob());
        end
      end
      rand_frames += frames_queued - phase_start;
      drain();
    end

    $display("run covered %0d frames over %0d register settings, %0d segments checked",
             frames_taken, phase_cnt, segs_checked);
    $display("input was held back on %0d cycles during receiver hold-off and stalls",
             in_stall_hits);
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // hard stop in case the block hangs
  initial begin
    #RUN_LIMIT_NS;
    $display("timeout with %0d segments still expected", seg_expect_q.size());
    $display("status: fail");
    $finish;
  end

endmodule

### sim.f
src/ssh_pkg.sv
src/ssh_cfg_regs.sv
src/ssh_tracker.sv
src/ssh_scaler.sv
src/speech_segment_hysteresis_top.sv
sim/tb_top.sv
